[rtl/tfb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tfb_pkg;

  localparam int unsigned MAX_FRAMES = 8;
  localparam int unsigned MAX_PIXELS = 4096;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PX_W    = 4 * CHAN_W;
  localparam int unsigned FP_W    = 13;
  localparam int unsigned WF_W    = 4;
  localparam int unsigned WGT_W   = 17;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned WGT_ONE = 65536;

  localparam logic [FP_W-1:0] FP_RESET = 13'd4096;
  localparam logic [WF_W-1:0] WF_RESET = 4'd8;

  localparam int unsigned APB_ADDR_W   = 3;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned REG_ADDR_LSB = 2;

  typedef enum logic {
    REG_FRAME_PIXELS  = 1'b0,
    REG_WINDOW_FRAMES = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

endpackage

`default_nettype wire

[rtl/temporal_frame_blend_core.sv]
// Temporal frame blend: weighted average of RGBA pixels over recent frames.
// Input channel: one pixel item (red, green, blue, alpha, frame_end) per
// handshake, taken when in_valid_i is high and in_stall_o is low. Pixels
// arrive in raster order; frame_end or the frame_pixels count closes a frame.
// Output channel: one blended pixel item per input item, in order, with
// frame_done set on the last pixel of a frame.
// Each item is written to the frame memory in its accept cycle, then the n
// frames held (n <= window_frames, a window of 0 taken as 1) are read back
// one per cycle through the single memory read port and fed to one shared
// multiply-accumulate lane; the sum then goes into the output register, and
// in_stall_o stays high while an item is in progress.
// Reset clears the frame counters and sets frame_pixels to 4096 and
// window_frames to 8; the frame memory is not cleared.
// A result waits in the output register while out_stall_i is high; the next
// item is still taken and worked on, and is held back until the register
// frees. Configuration is to be written over the APB port only while the
// block is idle, by the user; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module temporal_frame_blend_core #(
  parameter int unsigned MaxFrames = tfb_pkg::MAX_FRAMES,
  parameter int unsigned MaxPixels = tfb_pkg::MAX_PIXELS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tfb_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tfb_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tfb_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tfb_pkg::CHAN_W-1:0]        red_in_i,
  input  logic [tfb_pkg::CHAN_W-1:0]        green_in_i,
  input  logic [tfb_pkg::CHAN_W-1:0]        blue_in_i,
  input  logic [tfb_pkg::CHAN_W-1:0]        alpha_in_i,
  input  logic                              frame_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tfb_pkg::CHAN_W-1:0]        red_out_o,
  output logic [tfb_pkg::CHAN_W-1:0]        green_out_o,
  output logic [tfb_pkg::CHAN_W-1:0]        blue_out_o,
  output logic [tfb_pkg::CHAN_W-1:0]        alpha_out_o,
  output logic                              frame_done_o
);

  localparam int unsigned CW       = tfb_pkg::CHAN_W;
  localparam int unsigned WW       = tfb_pkg::WGT_W;
  localparam int unsigned FW       = tfb_pkg::FRAC_W;
  localparam int unsigned TW       = CW + WW;
  localparam int unsigned PW       = TW + CW;
  localparam int unsigned YW       = 2 * CW;
  localparam int unsigned Depth    = MaxFrames * MaxPixels;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned PosW     = $clog2(MaxPixels);
  localparam int unsigned AgeW     = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int unsigned NW       = $clog2(MaxFrames + 1);
  localparam int unsigned CmpW     = (PosW + 1 > tfb_pkg::FP_W) ? PosW + 1 : tfb_pkg::FP_W;
  localparam int unsigned WfCmpW   = (NW > tfb_pkg::WF_W) ? NW : tfb_pkg::WF_W;
  localparam int unsigned SumW     = CW + AgeW;
  localparam int unsigned LastBase = (MaxFrames - 1) * MaxPixels;
  localparam int unsigned ChanMax  = (1 << CW) - 1;

  // weight table, Q1.16, indexed by frames blended and age
  logic [WW-1:0] wrom [MaxFrames+1][MaxFrames];

  for (genvar gn = 0; gn <= MaxFrames; gn++) begin : g_wn
    for (genvar ga = 0; ga < MaxFrames; ga++) begin : g_wa
      localparam int unsigned Den = (gn > 1) ? 3 * gn * (gn - 1) : 1;
      localparam int unsigned Num = (ga < gn) ? 5 * (gn - 1) - 4 * ga : 0;
      localparam int unsigned Wgt = (gn <= 1) ? tfb_pkg::WGT_ONE :
                                    (Num * 2 * tfb_pkg::WGT_ONE + Den) / (2 * Den);
      assign wrom[gn][ga] = WW'(Wgt);
    end
  end

  // configuration
  logic [tfb_pkg::FP_W-1:0] fp_q;
  logic [tfb_pkg::WF_W-1:0] wf_q;
  logic                     cfg_we;
  logic                     reg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = paddr[tfb_pkg::REG_ADDR_LSB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q <= tfb_pkg::FP_RESET;
      wf_q <= tfb_pkg::WF_RESET;
    end else if (cfg_we) begin
      case (reg_sel)
        tfb_pkg::REG_FRAME_PIXELS:  fp_q <= pwdata[tfb_pkg::FP_W-1:0];
        tfb_pkg::REG_WINDOW_FRAMES: wf_q <= pwdata[tfb_pkg::WF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tfb_pkg::REG_FRAME_PIXELS:  prdata = tfb_pkg::APB_DATA_W'(fp_q);
      tfb_pkg::REG_WINDOW_FRAMES: prdata = tfb_pkg::APB_DATA_W'(wf_q);
      default:                    prdata = '0;
    endcase
  end

  // sequencer state
  tfb_pkg::state_e state_q;
  logic [PosW-1:0]  pos_q;
  logic [AgeW-1:0]  fh_q;
  logic [AddrW-1:0] base_q;
  logic [AddrW-1:0] rd_addr_q;
  logic [NW-1:0]    n_q;
  logic [AgeW-1:0]  age_q;
  logic             done_q;
  logic             s1_v_q, s2_v_q, s3_v_q;
  logic             out_valid_q;

  logic             accept, issue, last_age, pipe_empty, out_free, finish, done_d;
  logic [AddrW-1:0] wr_addr;
  logic [CmpW-1:0]  fp_ext, fp_eff;
  logic [WfCmpW-1:0] wf_ext, wf_eff;
  logic [NW-1:0]    fh_p1, n_d, age_ext;

  assign in_stall_o = (state_q != tfb_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign issue      = (state_q == tfb_pkg::ST_RUN);
  assign age_ext    = NW'(age_q);
  assign last_age   = (age_ext + NW'(1) == n_q);
  assign pipe_empty = !s1_v_q && !s2_v_q && !s3_v_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == tfb_pkg::ST_DRAIN) && pipe_empty && out_free;
  assign wr_addr    = base_q + AddrW'(pos_q);

  always_comb begin
    fp_ext = CmpW'(fp_q);
    if (fp_ext == '0) begin
      fp_eff = CmpW'(1);
    end else if (fp_ext > CmpW'(MaxPixels)) begin
      fp_eff = CmpW'(MaxPixels);
    end else begin
      fp_eff = fp_ext;
    end
    wf_ext = WfCmpW'(wf_q);
    if (wf_ext == '0) begin
      wf_eff = WfCmpW'(1);
    end else if (wf_ext > WfCmpW'(MaxFrames)) begin
      wf_eff = WfCmpW'(MaxFrames);
    end else begin
      wf_eff = wf_ext;
    end
    fh_p1  = NW'(fh_q) + NW'(1);
    n_d    = (WfCmpW'(fh_p1) < wf_eff) ? fh_p1 : NW'(wf_eff);
    done_d = frame_end_i || (CmpW'(pos_q) + CmpW'(1) >= fp_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tfb_pkg::ST_IDLE;
      pos_q       <= '0;
      fh_q        <= '0;
      base_q      <= '0;
      rd_addr_q   <= '0;
      n_q         <= '0;
      age_q       <= '0;
      done_q      <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      case (state_q)
        tfb_pkg::ST_IDLE: begin
          if (accept) begin
            rd_addr_q <= wr_addr;
            n_q       <= n_d;
            age_q     <= '0;
            done_q    <= done_d;
            if (done_d) begin
              pos_q  <= '0;
              base_q <= (base_q == AddrW'(LastBase)) ? '0 : base_q + AddrW'(MaxPixels);
              if (fh_q < AgeW'(MaxFrames - 1)) begin
                fh_q <= fh_q + AgeW'(1);
              end
            end else begin
              pos_q <= pos_q + PosW'(1);
            end
            state_q <= tfb_pkg::ST_RUN;
          end
        end
        tfb_pkg::ST_RUN: begin
          age_q     <= age_q + AgeW'(1);
          rd_addr_q <= (rd_addr_q < AddrW'(MaxPixels)) ? rd_addr_q + AddrW'(LastBase)
                                                        : rd_addr_q - AddrW'(MaxPixels);
          if (last_age) begin
            state_q <= tfb_pkg::ST_DRAIN;
          end
        end
        tfb_pkg::ST_DRAIN: begin
          if (finish) begin
            state_q <= tfb_pkg::ST_IDLE;
          end
        end
        default: state_q <= tfb_pkg::ST_IDLE;
      endcase
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // frame memory
  logic [tfb_pkg::PX_W-1:0] mem [Depth];
  logic [tfb_pkg::PX_W-1:0] rd_data_q;
  logic [WW-1:0]            w_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem[wr_addr] <= {alpha_in_i, blue_in_i, green_in_i, red_in_i};
    end
    if (issue) begin
      rd_data_q <= mem[rd_addr_q];
    end
  end

  // shared multiply-accumulate lane
  logic [TW-1:0]   t_q;
  logic [CW-1:0]   c_q  [3];
  logic [PW-1:0]   prod [3];
  logic [YW-1:0]   y_q  [3];
  logic [YW-1:0]   qs   [3];
  logic [CW-1:0]   at_q;
  logic [SumW-1:0] sum_q [4];

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = PW'(c_q[ch]) * PW'(t_q);
      qs[ch]   = y_q[ch] + YW'(y_q[ch][YW-1:CW]) + YW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    w_q  <= wrom[n_q][age_q];
    t_q  <= TW'(rd_data_q[3*CW +: CW]) * TW'(w_q);
    at_q <= t_q[FW +: CW];
    for (int ch = 0; ch < 3; ch++) begin
      c_q[ch] <= rd_data_q[ch*CW +: CW];
      y_q[ch] <= prod[ch][FW +: YW];
    end
    if (accept) begin
      for (int ch = 0; ch < 4; ch++) begin
        sum_q[ch] <= '0;
      end
    end else if (s3_v_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch] <= sum_q[ch] + SumW'(qs[ch][CW +: CW]);
      end
      sum_q[3] <= sum_q[3] + SumW'(at_q);
    end
  end

  // output register
  function automatic logic [CW-1:0] sat(input logic [SumW-1:0] s);
    return (s > SumW'(ChanMax)) ? CW'(ChanMax) : s[CW-1:0];
  endfunction

  logic [CW-1:0] red_q, green_q, blue_q, alpha_q;
  logic          fdone_q;

  always_ff @(posedge clk_i) begin
    if (finish) begin
      red_q   <= sat(sum_q[0]);
      green_q <= sat(sum_q[1]);
      blue_q  <= sat(sum_q[2]);
      alpha_q <= sat(sum_q[3]);
      fdone_q <= done_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = red_q;
  assign green_out_o  = green_q;
  assign blue_out_o   = blue_q;
  assign alpha_out_o  = alpha_q;
  assign frame_done_o = fdone_q;

endmodule

`default_nettype wire

[rtl/tfb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tfb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [tfb_pkg::APB_ADDR_W-1:0] paddr,
  input logic [tfb_pkg::APB_DATA_W-1:0] pwdata,
  input logic [tfb_pkg::APB_DATA_W-1:0] prdata,
  input logic                           pready,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [tfb_pkg::CHAN_W-1:0]     red_in_i,
  input logic [tfb_pkg::CHAN_W-1:0]     green_in_i,
  input logic [tfb_pkg::CHAN_W-1:0]     blue_in_i,
  input logic [tfb_pkg::CHAN_W-1:0]     alpha_in_i,
  input logic                           frame_end_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [tfb_pkg::CHAN_W-1:0]     red_out_o,
  input logic [tfb_pkg::CHAN_W-1:0]     green_out_o,
  input logic [tfb_pkg::CHAN_W-1:0]     blue_out_o,
  input logic [tfb_pkg::CHAN_W-1:0]     alpha_out_o,
  input logic                           frame_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable({red_out_o, green_out_o, blue_out_o, alpha_out_o, frame_done_o}))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before blend finished");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result item appeared without an item in progress");

endmodule

bind temporal_frame_blend_core tfb_checker u_tfb_checker (.*);

`default_nettype wire

[bench/tb_temporal_frame_blend_core.sv]
`timescale 1ns / 1ps

module tb_temporal_frame_blend_core;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned ChunkItems = 155;

  typedef struct packed {
    logic [tfb_pkg::CHAN_W-1:0] red;
    logic [tfb_pkg::CHAN_W-1:0] green;
    logic [tfb_pkg::CHAN_W-1:0] blue;
    logic [tfb_pkg::CHAN_W-1:0] alpha;
    logic                       last;
  } rgba_item_t;

  typedef struct packed {
    logic [tfb_pkg::CHAN_W-1:0] red;
    logic [tfb_pkg::CHAN_W-1:0] green;
    logic [tfb_pkg::CHAN_W-1:0] blue;
    logic [tfb_pkg::CHAN_W-1:0] alpha;
    logic                       done;
  } blend_px_t;

  logic                           clk_i;
  logic                           rst_ni = 1'b0;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [tfb_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [tfb_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [tfb_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [tfb_pkg::CHAN_W-1:0]     red_in_i = '0;
  logic [tfb_pkg::CHAN_W-1:0]     green_in_i = '0;
  logic [tfb_pkg::CHAN_W-1:0]     blue_in_i = '0;
  logic [tfb_pkg::CHAN_W-1:0]     alpha_in_i = '0;
  logic                           frame_end_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [tfb_pkg::CHAN_W-1:0]     red_out_o;
  logic [tfb_pkg::CHAN_W-1:0]     green_out_o;
  logic [tfb_pkg::CHAN_W-1:0]     blue_out_o;
  logic [tfb_pkg::CHAN_W-1:0]     alpha_out_o;
  logic                           frame_done_o;

  temporal_frame_blend_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .alpha_in_i  (alpha_in_i),
    .frame_end_i (frame_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .alpha_out_o (alpha_out_o),
    .frame_done_o(frame_done_o)
  );

  // shadow of the block: frame history, ring pointers and registers
  logic [tfb_pkg::PX_W-1:0] history_px [tfb_pkg::MAX_FRAMES*tfb_pkg::MAX_PIXELS];
  bit                       history_written [tfb_pkg::MAX_FRAMES*tfb_pkg::MAX_PIXELS];
  int unsigned              cur_pos = 0;
  int unsigned              cur_slot = 0;
  int unsigned              frames_kept = 0;
  logic [tfb_pkg::FP_W-1:0] cfg_frame_pixels = tfb_pkg::FP_RESET;
  logic [tfb_pkg::WF_W-1:0] cfg_window = tfb_pkg::WF_RESET;

  blend_px_t   expected_blends[$];
  int unsigned mismatches = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_frame_pixels();
    if (cfg_frame_pixels == 0) return 1;
    if (cfg_frame_pixels > tfb_pkg::MAX_PIXELS) return tfb_pkg::MAX_PIXELS;
    return cfg_frame_pixels;
  endfunction

  function automatic int unsigned frames_blended();
    int unsigned wf;
    int unsigned n;
    wf = (cfg_window == 0) ? 1 :
         ((cfg_window > tfb_pkg::MAX_FRAMES) ? tfb_pkg::MAX_FRAMES : cfg_window);
    n = frames_kept + 1;
    return (n > wf) ? wf : n;
  endfunction

  function automatic longint unsigned frame_weight(int unsigned n, int unsigned age);
    longint unsigned num;
    longint unsigned den;
    if (n <= 1) return tfb_pkg::WGT_ONE;
    if (age >= n) return 0;
    num = 5 * (n - 1) - 4 * age;
    den = 3 * n * (n - 1);
    return (num * tfb_pkg::WGT_ONE * 2 + den) / (2 * den);
  endfunction

  // true if p is out of frame or each older frame blended at p is stored
  function automatic bit history_complete(int unsigned p);
    int unsigned n;
    int unsigned s;
    if (p >= eff_frame_pixels()) return 1'b1;
    n = frames_blended();
    for (int unsigned a = 1; a < n; a++) begin
      s = (cur_slot + tfb_pkg::MAX_FRAMES - a) % tfb_pkg::MAX_FRAMES;
      if (!history_written[s*tfb_pkg::MAX_PIXELS + p]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_blend(input rgba_item_t px);
    int unsigned                n;
    int unsigned                s;
    logic [tfb_pkg::PX_W-1:0]   word;
    longint unsigned            w;
    longint unsigned            al;
    longint unsigned            c;
    longint unsigned            sum [4];
    blend_px_t                  res;
    logic [tfb_pkg::CHAN_W-1:0] chan [4];
    sum = '{0, 0, 0, 0};
    history_px[cur_slot*tfb_pkg::MAX_PIXELS + cur_pos] = {px.alpha, px.blue, px.green, px.red};
    history_written[cur_slot*tfb_pkg::MAX_PIXELS + cur_pos] = 1'b1;
    n = frames_blended();
    for (int unsigned a = 0; a < n; a++) begin
      s = (cur_slot + tfb_pkg::MAX_FRAMES - a) % tfb_pkg::MAX_FRAMES;
      word = history_px[s*tfb_pkg::MAX_PIXELS + cur_pos];
      w = frame_weight(n, a);
      al = word[31:24];
      for (int ch = 0; ch < 3; ch++) begin
        c = (word >> (tfb_pkg::CHAN_W * ch)) & 8'hff;
        sum[ch] += (c * w * al) / (255 * tfb_pkg::WGT_ONE);
      end
      sum[3] += (al * w) >> tfb_pkg::FRAC_W;
    end
    for (int ch = 0; ch < 4; ch++) begin
      chan[ch] = (sum[ch] > 255) ? 8'd255 : tfb_pkg::CHAN_W'(sum[ch]);
    end
    res.red = chan[0];
    res.green = chan[1];
    res.blue = chan[2];
    res.alpha = chan[3];
    res.done = px.last || (cur_pos + 1 >= eff_frame_pixels());
    if (res.done) begin
      cur_pos = 0;
      cur_slot = (cur_slot + 1) % tfb_pkg::MAX_FRAMES;
      if (frames_kept < tfb_pkg::MAX_FRAMES - 1) frames_kept++;
    end else begin
      cur_pos++;
    end
    expected_blends = {expected_blends, res};
  endtask

  task automatic send_pixel(input rgba_item_t px);
    // close the frame early where the next position has no full history
    if (!history_complete(cur_pos + 1)) px.last = 1'b1;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    red_in_i    <= px.red;
    green_in_i  <= px.green;
    blue_in_i   <= px.blue;
    alpha_in_i  <= px.alpha;
    frame_end_i <= px.last;
    do @(posedge clk_i); while (in_stall_o);
    predict_blend(px);
  endtask

  task automatic drain_blends();
    in_valid_i <= 1'b0;
    while (expected_blends.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_register(input tfb_pkg::reg_idx_e idx,
                                input logic [tfb_pkg::APB_DATA_W-1:0] value);
    logic [tfb_pkg::APB_ADDR_W-1:0] addr;
    drain_blends();
    repeat (tfb_pkg::MAX_FRAMES + 6) @(posedge clk_i);
    addr = tfb_pkg::APB_ADDR_W'(idx);
    addr = addr << tfb_pkg::REG_ADDR_LSB;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == tfb_pkg::REG_FRAME_PIXELS) cfg_frame_pixels = value[tfb_pkg::FP_W-1:0];
    else cfg_window = value[tfb_pkg::WF_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [tfb_pkg::CHAN_W-1:0] random_channel();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return '0;
    if (pick < 16) return '1;
    return tfb_pkg::CHAN_W'($urandom_range(0, 255));
  endfunction

  task automatic test_single_pixel_frames();
    logic [tfb_pkg::PX_W-1:0] pattern [12];
    rgba_item_t               px;
    pattern = '{32'hffffffff, 32'h00000000, 32'h80ff00ff, 32'hff00ff00,
                32'hfffe8001, 32'h01ffffff, 32'h55aa55aa, 32'hffffffff,
                32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff};
    foreach (pattern[i]) begin
      px.red   = pattern[i][7:0];
      px.green = pattern[i][15:8];
      px.blue  = pattern[i][23:16];
      px.alpha = pattern[i][31:24];
      px.last  = 1'b1;
      send_pixel(px);
    end
  endtask

  task automatic test_register_limits();
    rgba_item_t px;
    write_register(tfb_pkg::REG_WINDOW_FRAMES, 32'd0);
    px = '{8'd255, 8'd0, 8'd128, 8'd255, 1'b1};
    send_pixel(px);
    px = '{8'd0, 8'd255, 8'd1, 8'd254, 1'b1};
    send_pixel(px);
    write_register(tfb_pkg::REG_WINDOW_FRAMES, 32'd15);
    px = '{8'd200, 8'd100, 8'd50, 8'd255, 1'b1};
    send_pixel(px);
    px = '{8'd255, 8'd255, 8'd255, 8'd0, 1'b1};
    send_pixel(px);
    write_register(tfb_pkg::REG_FRAME_PIXELS, 32'd0);
    px = '{8'd10, 8'd20, 8'd30, 8'd40, 1'b0};
    send_pixel(px);
    px = '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0};
    send_pixel(px);
    write_register(tfb_pkg::REG_FRAME_PIXELS, 32'd8191);
    px = '{8'd1, 8'd2, 8'd3, 8'd4, 1'b0};
    send_pixel(px);
    px = '{8'd255, 8'd0, 8'd255, 8'd0, 1'b1};
    send_pixel(px);
  endtask

  task automatic test_random_blend(input int unsigned idle_pct, input int unsigned stall_pct);
    rgba_item_t  px;
    int unsigned pick;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        write_register(tfb_pkg::REG_FRAME_PIXELS, $urandom_range(1, 48));
      end else if (pick < 90) begin
        write_register(tfb_pkg::REG_FRAME_PIXELS, $urandom_range(49, 300));
      end else begin
        write_register(tfb_pkg::REG_FRAME_PIXELS, $urandom_range(0, 8191));
      end
      write_register(tfb_pkg::REG_WINDOW_FRAMES, $urandom_range(0, 15));
      for (int i = 0; i < ChunkItems; i++) begin
        px.red   = random_channel();
        px.green = random_channel();
        px.blue  = random_channel();
        px.alpha = random_channel();
        px.last  = ($urandom_range(0, 99) < 4) || (i == ChunkItems - 1);
        if ($urandom_range(0, 199) == 0) drain_blends();
        send_pixel(px);
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    blend_px_t got;
    blend_px_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{red_out_o, green_out_o, blue_out_o, alpha_out_o, frame_done_o};
      if (expected_blends.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected blended item, expected none, got r%0d g%0d b%0d a%0d done%0b",
                 $time, got.red, got.green, got.blue, got.alpha, got.done);
      end else begin
        want = expected_blends.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.done !== want.done) begin
          mismatches++;
          $display({"%0t: blended item expected r%0d g%0d b%0d a%0d done%0b, ",
                    "got r%0d g%0d b%0d a%0d done%0b"},
                   $time, want.red, want.green, want.blue, want.alpha, want.done,
                   got.red, got.green, got.blue, got.alpha, got.done);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = 18;
    receiver_stall_pct = 74;
    test_single_pixel_frames();
    test_register_limits();
    test_random_blend(18, 74);
    test_random_blend(74, 18);
    test_random_blend(0, 0);
    drain_blends();
    repeat (tfb_pkg::MAX_FRAMES + 12) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
